// File: src/atcl_pkg.sv
// Shared types and constants for the ANSI text console layout block.
package atcl_pkg;

    localparam int unsigned COL_W  = 7;
    localparam int unsigned LINE_W = 10;
    localparam int unsigned IDX_W  = 9;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned FG_W   = 5;
    localparam int unsigned ACC_W  = 8;

    localparam logic [COL_W-1:0] COLUMNS_RESET = 7'd102;
    localparam logic [FG_W-1:0]  FG_DEFAULT    = 5'd16;

    // Console byte codes with a meaning of their own.
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LBRK  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_SGR_M = 8'h6D;

    // Color selection codes inside an escape sequence.
    localparam logic [ACC_W-1:0] SGR_DEFAULT      = 8'd0;
    localparam logic [ACC_W-1:0] SGR_DARK_FIRST   = 8'd30;
    localparam logic [ACC_W-1:0] SGR_DARK_LAST    = 8'd37;
    localparam logic [ACC_W-1:0] SGR_BRIGHT_FIRST = 8'd90;
    localparam logic [ACC_W-1:0] SGR_BRIGHT_LAST  = 8'd97;
    localparam logic [ACC_W-1:0] FG_BRIGHT_BASE   = 8'd8;

    // Input action codes.
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    // Result kind codes.
    localparam logic KIND_CLEAR = 1'b0;
    localparam logic KIND_DRAW  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  line_index;
        logic [COL_W-1:0]  column_index;
        logic [CHAR_W-1:0] char_code;
        logic [FG_W-1:0]   fg_color;
        logic              last;
    } result_t;

    // Results produced by one processed item, handed to the output queue.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// File: src/ansi_text_console_layout.sv
// An accepted item is held in the input register and is processed by the engine once the
// queue has room for a pair of results; its first result is then written to the queue and offered.
// Throughput: one item per cycle while each item yields at most one result and the output is
// not stalled; an item that draws the last column and opens a new line yields two, and the
// single-result output port then sets the pace. rst_n clears the cursor, color, escape state
// and queue at once; the column register resets to 102.
module ansi_text_console_layout
    import atcl_pkg::*;
#(
    parameter int MAX_LINES = 512,
    parameter int TAB_STOP  = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    // Console item channel.
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  logic [CHAR_W-1:0] char_in,
    // Result item channel.
    output logic              out_valid,
    input  logic              out_stall,
    output logic              kind,
    output logic [IDX_W-1:0]  line_index,
    output logic [COL_W-1:0]  column_index,
    output logic [CHAR_W-1:0] char_code,
    output logic [FG_W-1:0]   fg_color,
    output logic              last,
    // Column register write channel.
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [COL_W-1:0]  cfg_data
);

    logic              in_full_reg, in_full_next;
    logic              action_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [COL_W-1:0]  columns_reg;
    logic              accept;
    logic              go;
    logic              room;
    push_t             push;
    result_t           head;

    // Always writable; the user must change the column register only while idle; not enforced.
    assign cfg_ready = 1'b1;

    // The input register drains into the engine whenever the queue can take a pair of
    // results, so the stall never depends on the output side in the same cycle.
    assign go       = in_full_reg && room;
    assign in_stall = in_full_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (go)
        begin
            in_full_next = 1'b0;
        end
        else
        begin
            in_full_next = in_full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            columns_reg <= COLUMNS_RESET;
        end
        else
        begin
            in_full_reg <= in_full_next;
            if (cfg_valid && cfg_ready)
            begin
                columns_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            char_reg   <= char_in;
        end
    end

    atcl_engine #(
        .MAX_LINES (MAX_LINES),
        .TAB_STOP  (TAB_STOP)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .action  (action_reg),
        .char_in (char_reg),
        .columns (columns_reg),
        .push    (push)
    );

    atcl_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign kind         = head.kind;
    assign line_index   = head.line_index;
    assign column_index = head.column_index;
    assign char_code    = head.char_code;
    assign fg_color     = head.fg_color;
    assign last         = head.last;

endmodule

// File: src/atcl_engine.sv
// Cursor, color and escape state with the per-item layout logic.
module atcl_engine
    import atcl_pkg::*;
#(
    parameter int MAX_LINES = 512,
    parameter int TAB_STOP  = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic              action,
    input  logic [CHAR_W-1:0] char_in,
    input  logic [COL_W-1:0]  columns,
    output push_t             push
);

    // The column is divided by the tab width through a reciprocal multiply,
    // which is exact for 7-bit columns and tab widths up to 32.
    localparam int TAB_SHIFT = 12;
    localparam int TAB_RECIP = ((1 << TAB_SHIFT) + TAB_STOP - 1) / TAB_STOP;
    localparam int PROD_W    = COL_W + TAB_SHIFT + 1;

    logic [COL_W-1:0]  cur_column_reg, cur_column_next;
    logic [LINE_W-1:0] cur_line_reg, cur_line_next;
    logic [FG_W-1:0]   cur_fg_reg, cur_fg_next;
    logic              in_escape_reg, in_escape_next;
    logic              in_csi_reg, in_csi_next;
    logic [ACC_W-1:0]  code_accum_reg, code_accum_next;
    logic              code_present_reg, code_present_next;
    logic              frame_done_reg, frame_done_next;

    logic [COL_W-1:0]  limit;
    logic [LINE_W:0]   nxt_line;
    logic              line_ok;
    logic [PROD_W-1:0] tab_prod;
    logic [COL_W-1:0]  tab_quot;
    logic [COL_W:0]    tab_col;
    logic [COL_W:0]    step_col;
    logic [11:0]       accum_x10;
    logic [3:0]        digit;
    logic              newline;
    logic              draw;
    result_t           res0;
    result_t           res1;
    logic [1:0]        n;

    always_comb
    begin
        cur_column_next   = cur_column_reg;
        cur_line_next     = cur_line_reg;
        cur_fg_next       = cur_fg_reg;
        in_escape_next    = in_escape_reg;
        in_csi_next       = in_csi_reg;
        code_accum_next   = code_accum_reg;
        code_present_next = code_present_reg;
        frame_done_next   = frame_done_reg;
        res0              = '0;
        res1              = '0;
        n                 = 2'd0;
        newline           = 1'b0;
        draw              = 1'b0;

        // A zero register acts as one column.
        limit     = (columns == '0) ? COL_W'(1) : columns;
        nxt_line  = {1'b0, cur_line_reg} + (LINE_W+1)'(1);
        line_ok   = nxt_line < (LINE_W+1)'(MAX_LINES);
        tab_prod  = PROD_W'(cur_column_reg) * PROD_W'(TAB_RECIP);
        tab_quot  = tab_prod[COL_W+TAB_SHIFT-1:TAB_SHIFT];
        tab_col   = (COL_W+1)'((32'(tab_quot) + 1) * TAB_STOP);
        step_col  = {1'b0, cur_column_reg} + (COL_W+1)'(1);
        digit     = 4'(char_in - CH_ZERO);
        accum_x10 = {1'b0, code_accum_reg, 3'b000} + {3'b000, code_accum_reg, 1'b0}
                    + 12'(digit);

        if (action == ACT_RESTART)
        begin
            cur_column_next   = '0;
            cur_line_next     = '0;
            cur_fg_next       = FG_DEFAULT;
            in_escape_next    = 1'b0;
            in_csi_next       = 1'b0;
            code_accum_next   = '0;
            code_present_next = 1'b0;
            frame_done_next   = 1'b0;
            res0.kind         = KIND_CLEAR;
            res0.fg_color     = FG_DEFAULT;
            n                 = 2'd1;
        end
        else if (!frame_done_reg)
        begin
            case (char_in)
                CH_CR:  cur_column_next = '0;
                CH_LF:  newline = 1'b1;
                CH_BS:
                begin
                    if (cur_column_reg != '0)
                    begin
                        cur_column_next = cur_column_reg - COL_W'(1);
                    end
                end
                CH_TAB:
                begin
                    if (tab_col >= {1'b0, limit})
                    begin
                        newline = 1'b1;
                    end
                    else
                    begin
                        cur_column_next = tab_col[COL_W-1:0];
                    end
                end
                CH_ESC: in_escape_next = 1'b1;
                default:
                begin
                    if (in_escape_reg)
                    begin
                        if (in_csi_reg)
                        begin
                            if (char_in inside {[CH_ZERO:CH_NINE]})
                            begin
                                code_present_next = 1'b1;
                                if (!code_present_reg)
                                begin
                                    code_accum_next = ACC_W'(digit);
                                end
                                else if (accum_x10 > 12'd255)
                                begin
                                    code_accum_next = 8'd255;
                                end
                                else
                                begin
                                    code_accum_next = accum_x10[ACC_W-1:0];
                                end
                            end
                            if (char_in == CH_SEMI || char_in == CH_SGR_M)
                            begin
                                if (code_present_reg)
                                begin
                                    if (code_accum_reg == SGR_DEFAULT)
                                    begin
                                        cur_fg_next = FG_DEFAULT;
                                    end
                                    else if (code_accum_reg inside
                                             {[SGR_DARK_FIRST:SGR_DARK_LAST]})
                                    begin
                                        cur_fg_next = FG_W'(code_accum_reg - SGR_DARK_FIRST);
                                    end
                                    else if (code_accum_reg inside
                                             {[SGR_BRIGHT_FIRST:SGR_BRIGHT_LAST]})
                                    begin
                                        cur_fg_next = FG_W'(code_accum_reg - SGR_BRIGHT_FIRST
                                                            + FG_BRIGHT_BASE);
                                    end
                                end
                                code_accum_next   = '0;
                                code_present_next = 1'b0;
                            end
                            if (char_in == CH_SGR_M)
                            begin
                                in_csi_next    = 1'b0;
                                in_escape_next = 1'b0;
                            end
                        end
                        if (char_in == CH_LBRK)
                        begin
                            in_csi_next       = 1'b1;
                            code_accum_next   = '0;
                            code_present_next = 1'b0;
                        end
                    end
                    else if (char_in inside {[8'h20:8'h7F], [8'hA0:8'hFF]})
                    begin
                        draw = 1'b1;
                        if (step_col >= {1'b0, limit})
                        begin
                            newline = 1'b1;
                        end
                        else
                        begin
                            cur_column_next = step_col[COL_W-1:0];
                        end
                    end
                end
            endcase

            if (draw)
            begin
                res0.kind         = KIND_DRAW;
                res0.line_index   = cur_line_reg[IDX_W-1:0];
                res0.column_index = cur_column_reg;
                res0.char_code    = char_in;
                res0.fg_color     = cur_fg_reg;
                n                 = 2'd1;
            end

            if (newline)
            begin
                cur_column_next = '0;
                cur_line_next   = nxt_line[LINE_W-1:0];
                if (line_ok)
                begin
                    if (draw)
                    begin
                        res1.kind       = KIND_CLEAR;
                        res1.line_index = nxt_line[IDX_W-1:0];
                        res1.fg_color   = FG_DEFAULT;
                        n               = 2'd2;
                    end
                    else
                    begin
                        res0.kind       = KIND_CLEAR;
                        res0.line_index = nxt_line[IDX_W-1:0];
                        res0.fg_color   = FG_DEFAULT;
                        n               = 2'd1;
                    end
                end
                else
                begin
                    frame_done_next = 1'b1;
                end
            end
        end

        // The final result of the item carries the last flag.
        if (n == 2'd2)
        begin
            res1.last = 1'b1;
        end
        else
        begin
            res0.last = 1'b1;
        end
    end

    assign push.count  = go ? n : 2'd0;
    assign push.first  = res0;
    assign push.second = res1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_column_reg   <= '0;
            cur_line_reg     <= '0;
            cur_fg_reg       <= FG_DEFAULT;
            in_escape_reg    <= 1'b0;
            in_csi_reg       <= 1'b0;
            code_accum_reg   <= '0;
            code_present_reg <= 1'b0;
            frame_done_reg   <= 1'b0;
        end
        else if (go)
        begin
            cur_column_reg   <= cur_column_next;
            cur_line_reg     <= cur_line_next;
            cur_fg_reg       <= cur_fg_next;
            in_escape_reg    <= in_escape_next;
            in_csi_reg       <= in_csi_next;
            code_accum_reg   <= code_accum_next;
            code_present_reg <= code_present_next;
            frame_done_reg   <= frame_done_next;
        end
    end

endmodule

// File: src/atcl_out_fifo.sv
// Four-entry result queue that takes up to two results per cycle.
module atcl_out_fifo
    import atcl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t head
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    // Room for a full pair is judged from the registered count alone.
    assign room      = (count_reg <= (PTR_W+1)'(DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/atcl_checker.sv
// Port-level checks for the ANSI text console layout block and their binding.
module atcl_checker
    import atcl_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic              kind,
    input logic [IDX_W-1:0]  line_index,
    input logic [COL_W-1:0]  column_index,
    input logic [CHAR_W-1:0] char_code,
    input logic [FG_W-1:0]   fg_color,
    input logic              last
);

    // A stalled result holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(line_index)
            && $stable(column_index) && $stable(char_code) && $stable(fg_color)
            && $stable(last))
    else $error("stalled result changed");

    // A line clear is always the final result of its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_CLEAR |-> last)
    else $error("line clear without last");

    // A line clear carries column zero, no character and the default color.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_CLEAR |-> column_index == '0 && char_code == '0
            && fg_color == FG_DEFAULT)
    else $error("line clear with stray fields");

    // A drawn cell that is not final is followed by the clear of the next line.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && kind == KIND_DRAW && !last |=>
            out_valid && kind == KIND_CLEAR && line_index == $past(line_index) + IDX_W'(1))
    else $error("wrap clear missing after drawn cell");

    // Colors stay within the palette or the default.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fg_color <= FG_DEFAULT)
    else $error("color out of range");

endmodule

bind ansi_text_console_layout atcl_checker u_atcl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .line_index   (line_index),
    .column_index (column_index),
    .char_code    (char_code),
    .fg_color     (fg_color),
    .last         (last)
);

// File: dv/ansi_text_console_layout_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ANSI text console layout block.
module ansi_text_console_layout_tb;
    import atcl_pkg::*;

    // The line limit is lowered from its default so that random traffic fills
    // the frame again and again and the frame-full behavior gets exercised.
    localparam int MAX_LINES = 48;
    localparam int TAB_STOP  = 8;

    // Byte ranges that draw a cell.
    localparam logic [CHAR_W-1:0] PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_HI = 8'h7F;
    localparam logic [CHAR_W-1:0] HIGH_LO  = 8'hA0;

    // Select Graphic Rendition codes that change the foreground color.
    localparam int SGR_RESET_CODE = 0;
    localparam int SGR_DARK_LO    = 30;
    localparam int SGR_DARK_HI    = 37;
    localparam int SGR_BRIGHT_LO  = 90;
    localparam int SGR_BRIGHT_HI  = 97;
    localparam int BRIGHT_BASE    = 8;
    localparam int SGR_MAX        = 255;

    localparam int MAX_REPORTS      = 20;
    localparam int ITEMS_PER_PHASE  = 69;
    localparam int QUIET_CYCLES     = 8;
    localparam int NUM_FIXED_PHASES = 8;
    localparam int RUN_LIMIT_NS     = 2000000;

    // Opening bytes: every printable boundary, ignored bytes, cursor moves with
    // the backspace clamp, a tab, a two-code color sequence and a newline. The
    // cursor is left at column 4 so that a lowered column limit can be hit.
    localparam logic [CHAR_W-1:0] OPENING_BYTES [25] = '{
        8'h41, PRINT_LO, HIGH_LO, 8'hFF, PRINT_HI, 8'h80, 8'h00, CH_BS, CH_CR, CH_BS,
        CH_TAB, CH_ESC, CH_LBRK, 8'h33, 8'h31, CH_SEMI, CH_NINE, 8'h37, CH_SGR_M,
        8'h61, CH_LF, 8'h62, 8'h63, 8'h64, 8'h65
    };

    // Column settings per phase: the extremes, zero (acts as one column), small
    // values that make lines wrap often, and the reset value. A wide setting is
    // followed by a narrow one so the cursor often sits beyond the new limit.
    localparam logic [COL_W-1:0] PHASE_COLUMNS [NUM_FIXED_PHASES] = '{
        7'd1, 7'd127, 7'd9, 7'd0, 7'd40, 7'd16, 7'd102, 7'd5
    };

    // Idle patterns in percent: none, sender only, receiver only, both.
    localparam int unsigned SEND_IDLE_PCT [4] = '{0, 76, 0, 21};
    localparam int unsigned STALL_PCT     [4] = '{0, 0, 76, 21};

    // The scoreboard keeps its own copy of the cursor, the color and the escape
    // parser. Each accepted item is run through that copy, and the cell draws
    // and line clears it produces wait in order for the block's results.
    class console_scoreboard;
        result_t           pending_events[$];
        result_t           step_events[$];
        logic [COL_W-1:0]  col_limit;
        logic [COL_W-1:0]  cursor_col;
        logic [LINE_W-1:0] cursor_line;
        logic [FG_W-1:0]   pen_fg;
        logic              esc_pending;
        logic              csi_open;
        logic              sgr_seen;
        logic [ACC_W-1:0]  sgr_value;
        logic              frame_full;
        int unsigned       mismatches;
        int unsigned       draws_seen;
        int unsigned       clears_seen;
        int unsigned       frame_fills;
        int unsigned       restarts;
        int unsigned       live_items;

        function new();
            col_limit = COLUMNS_RESET;
            restart_frame();
        endfunction

        function void restart_frame();
            cursor_col  = '0;
            cursor_line = '0;
            pen_fg      = FG_DEFAULT;
            esc_pending = 1'b0;
            csi_open    = 1'b0;
            sgr_seen    = 1'b0;
            sgr_value   = '0;
            frame_full  = 1'b0;
        endfunction

        function void set_columns(logic [COL_W-1:0] value);
            col_limit = value;
        endfunction

        function result_t make_event(logic k, int unsigned line, int unsigned col,
                                     logic [CHAR_W-1:0] ch, logic [FG_W-1:0] fg);
            result_t ev;
            ev.kind         = k;
            ev.line_index   = IDX_W'(line);
            ev.column_index = COL_W'(col);
            ev.char_code    = ch;
            ev.fg_color     = fg;
            ev.last         = 1'b0;
            return ev;
        endfunction

        // A new line is announced by a clear unless it would pass the line
        // limit, in which case the frame is full and stays silent.
        function void open_next_line();
            int unsigned nxt;
            nxt         = cursor_line + 1;
            cursor_col  = '0;
            cursor_line = LINE_W'(nxt);
            if (nxt >= MAX_LINES)
            begin
                frame_full = 1'b1;
                frame_fills++;
            end
            else
            begin
                step_events.push_back(make_event(KIND_CLEAR, nxt, 0, '0, FG_DEFAULT));
            end
        endfunction

        function void note_item(logic act, logic [CHAR_W-1:0] ch);
            int unsigned limit;
            int unsigned nc;
            int unsigned v;
            step_events.delete();
            limit = (col_limit == 0) ? 1 : col_limit;
            if (act == ACT_RESTART)
            begin
                restart_frame();
                restarts++;
                live_items++;
                step_events.push_back(make_event(KIND_CLEAR, 0, 0, '0, FG_DEFAULT));
            end
            else if (!frame_full)
            begin
                live_items++;
                case (ch)
                    CH_CR: cursor_col = '0;
                    CH_LF: open_next_line();
                    CH_BS: if (cursor_col != 0) cursor_col--;
                    CH_TAB:
                    begin
                        nc = (cursor_col / TAB_STOP + 1) * TAB_STOP;
                        if (nc >= limit)
                            open_next_line();
                        else
                            cursor_col = COL_W'(nc);
                    end
                    CH_ESC: esc_pending = 1'b1;
                    default:
                    begin
                        if (esc_pending)
                        begin
                            if (csi_open)
                            begin
                                // Digits build a decimal code that saturates.
                                if (ch >= CH_ZERO && ch <= CH_NINE)
                                begin
                                    v = ch - CH_ZERO;
                                    if (!sgr_seen)
                                    begin
                                        sgr_value = ACC_W'(v);
                                        sgr_seen  = 1'b1;
                                    end
                                    else
                                    begin
                                        v = int'(sgr_value) * 10 + v;
                                        sgr_value = (v > SGR_MAX) ? ACC_W'(SGR_MAX)
                                                                  : ACC_W'(v);
                                    end
                                end
                                // A separator or the final letter applies a pending code.
                                if (ch == CH_SEMI || ch == CH_SGR_M)
                                begin
                                    if (sgr_seen)
                                    begin
                                        if (sgr_value == SGR_RESET_CODE)
                                            pen_fg = FG_DEFAULT;
                                        else if (sgr_value >= SGR_DARK_LO &&
                                                 sgr_value <= SGR_DARK_HI)
                                            pen_fg = FG_W'(sgr_value - SGR_DARK_LO);
                                        else if (sgr_value >= SGR_BRIGHT_LO &&
                                                 sgr_value <= SGR_BRIGHT_HI)
                                            pen_fg = FG_W'(sgr_value - SGR_BRIGHT_LO
                                                           + BRIGHT_BASE);
                                    end
                                    sgr_value = '0;
                                    sgr_seen  = 1'b0;
                                end
                                if (ch == CH_SGR_M)
                                begin
                                    csi_open    = 1'b0;
                                    esc_pending = 1'b0;
                                end
                            end
                            if (ch == CH_LBRK)
                            begin
                                csi_open  = 1'b1;
                                sgr_value = '0;
                                sgr_seen  = 1'b0;
                            end
                        end
                        else if ((ch >= PRINT_LO && ch <= PRINT_HI) || ch >= HIGH_LO)
                        begin
                            // The cell is drawn even when the cursor already sits
                            // past a lowered limit; the line wraps right after.
                            step_events.push_back(make_event(KIND_DRAW, cursor_line,
                                                             cursor_col, ch, pen_fg));
                            nc = cursor_col + 1;
                            if (nc >= limit)
                                open_next_line();
                            else
                                cursor_col = COL_W'(nc);
                        end
                    end
                endcase
            end
            if (step_events.size() != 0)
                step_events[step_events.size() - 1].last = 1'b1;
            foreach (step_events[i])
                pending_events.push_back(step_events[i]);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_event(result_t got);
            result_t want;
            if (pending_events.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d line %0d column %0d",
                                          got.kind, got.line_index, got.column_index));
                return;
            end
            want = pending_events.pop_front();
            if (got.kind != want.kind)
                report_mismatch($sformatf("kind got %0d, want %0d", got.kind, want.kind));
            if (got.line_index != want.line_index)
                report_mismatch($sformatf("line_index got %0d, want %0d",
                                          got.line_index, want.line_index));
            if (got.column_index != want.column_index)
                report_mismatch($sformatf("column_index got %0d, want %0d",
                                          got.column_index, want.column_index));
            if (got.char_code != want.char_code)
                report_mismatch($sformatf("char_code got 0x%02h, want 0x%02h",
                                          got.char_code, want.char_code));
            if (got.fg_color != want.fg_color)
                report_mismatch($sformatf("fg_color got %0d, want %0d",
                                          got.fg_color, want.fg_color));
            if (got.last != want.last)
                report_mismatch($sformatf("last got %0d, want %0d", got.last, want.last));
            if (want.kind == KIND_DRAW)
                draws_seen++;
            else
                clears_seen++;
        endtask

        task finish_check();
            if (pending_events.size() != 0)
                report_mismatch($sformatf("%0d expected results never arrived",
                                          pending_events.size()));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              action;
    logic [CHAR_W-1:0] char_in;
    logic              out_valid;
    logic              out_stall;
    logic              kind;
    logic [IDX_W-1:0]  line_index;
    logic [COL_W-1:0]  column_index;
    logic [CHAR_W-1:0] char_code;
    logic [FG_W-1:0]   fg_color;
    logic              last;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [COL_W-1:0]  cfg_data;

    int unsigned       send_idle_pct;
    int unsigned       stall_pct;
    int unsigned       items_sent;
    int unsigned       column_writes;
    console_scoreboard sb;

    ansi_text_console_layout #(
        .MAX_LINES (MAX_LINES),
        .TAB_STOP  (TAB_STOP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .char_in      (char_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .line_index   (line_index),
        .column_index (column_index),
        .char_code    (char_code),
        .fg_color     (fg_color),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Results are taken at the rising edge where valid is high and stall is
    // low; the values read here are the ones held before the edge. The stall
    // for the next cycle is then drawn at random for the current idle pattern.
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind         = kind;
            got.line_index   = line_index;
            got.column_index = column_index;
            got.char_code    = char_code;
            got.fg_color     = fg_color;
            got.last         = last;
            sb.check_event(got);
        end
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // Offers one item, idling first at random, and holds it until accepted.
    // Valid stays high from one item to the next when no idle cycle is drawn,
    // since send_item lowers it only while idling; wait_quiet lowers it too.
    task automatic send_item(logic act, logic [CHAR_W-1:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        char_in  <= ch;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(act, ch);
        items_sent++;
    endtask

    // Sends one color sequence with up to three codes. A broken one may carry
    // stray bytes or lack its final letter, which leaves the parser waiting.
    task automatic send_sgr(bit broken);
        int unsigned codes;
        int unsigned code;
        int unsigned k;
        int unsigned r;
        send_item(ACT_BYTE, CH_ESC);
        if (broken && $urandom_range(3) == 0)
            send_item(ACT_BYTE, CHAR_W'($urandom_range(255)));
        send_item(ACT_BYTE, CH_LBRK);
        codes = $urandom_range(3);
        for (k = 0; k < codes; k++)
        begin
            r = $urandom_range(99);
            if (r < 20)
                code = SGR_RESET_CODE;
            else if (r < 50)
                code = $urandom_range(SGR_DARK_HI, SGR_DARK_LO);
            else if (r < 80)
                code = $urandom_range(SGR_BRIGHT_HI, SGR_BRIGHT_LO);
            else if (r < 90)
                code = $urandom_range(SGR_MAX);
            else
                code = $urandom_range(999, SGR_MAX + 1);
            if (code >= 100)
                send_item(ACT_BYTE, CHAR_W'(CH_ZERO + code / 100));
            if (code >= 10)
                send_item(ACT_BYTE, CHAR_W'(CH_ZERO + (code / 10) % 10));
            send_item(ACT_BYTE, CHAR_W'(CH_ZERO + code % 10));
            if (broken && $urandom_range(4) == 0)
                send_item(ACT_BYTE, CHAR_W'($urandom_range(255)));
            if (k + 1 < codes)
                send_item(ACT_BYTE, CH_SEMI);
        end
        if (!broken || $urandom_range(1) == 0)
            send_item(ACT_BYTE, CH_SGR_M);
    endtask

    // Mostly text and cursor moves with well-formed color sequences; the rest
    // is broken sequences, raw bytes of any value and the odd restart.
    task automatic send_random_unit();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 2)
        begin
            send_item(ACT_RESTART, CHAR_W'($urandom_range(255)));
        end
        else if (pick < 50)
        begin
            if ($urandom_range(3) == 0)
                send_item(ACT_BYTE, CHAR_W'($urandom_range(255, HIGH_LO)));
            else
                send_item(ACT_BYTE, CHAR_W'($urandom_range(PRINT_HI, PRINT_LO)));
        end
        else if (pick < 62)
        begin
            case ($urandom_range(3))
                0: send_item(ACT_BYTE, CH_CR);
                1: send_item(ACT_BYTE, CH_LF);
                2: send_item(ACT_BYTE, CH_BS);
                default: send_item(ACT_BYTE, CH_TAB);
            endcase
        end
        else if (pick < 80)
        begin
            send_sgr(1'b0);
        end
        else if (pick < 88)
        begin
            send_sgr(1'b1);
        end
        else
        begin
            send_item(ACT_BYTE, CHAR_W'($urandom_range(255)));
        end
    endtask

    // The register is written only when the block is idle.
    task automatic write_columns(logic [COL_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_columns(value);
        column_writes++;
    endtask

    // Waits for every expected result, then idles on in case the last items
    // were ones that produce nothing and are still being processed.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (sb.pending_events.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned      phase;
        int unsigned      first_item;
        int               idx;
        logic [COL_W-1:0] cols;
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_BYTE;
        char_in       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        out_stall     = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        items_sent    = 0;
        column_writes = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening at the reset column setting, starting with a restart.
        send_item(ACT_RESTART, 8'hFF);
        for (idx = 0; idx < $size(OPENING_BYTES); idx++)
            send_item(ACT_BYTE, OPENING_BYTES[idx]);

        // Lower the limit below the cursor: the next cell is still drawn at
        // column 4 and the line then wraps.
        wait_quiet();
        write_columns(COL_W'(2));
        send_item(ACT_BYTE, 8'h66);

        // Random phases, each with its own column setting and idle pattern,
        // and each sending about the same number of items.
        for (phase = 0; phase <= NUM_FIXED_PHASES; phase++)
        begin
            wait_quiet();
            if (phase < NUM_FIXED_PHASES)
                cols = PHASE_COLUMNS[phase];
            else
                cols = COL_W'($urandom_range(126, 1));
            write_columns(cols);
            send_idle_pct = SEND_IDLE_PCT[phase % 4];
            stall_pct     = STALL_PCT[phase % 4];
            first_item    = items_sent;
            while (items_sent - first_item < ITEMS_PER_PHASE)
                send_random_unit();
        end

        wait_quiet();
        repeat (QUIET_CYCLES * 4) @(posedge clk);
        sb.finish_check();
        $display("Coverage: %0d items (%0d acted on) over %0d column settings; %0d draws, %0d clears.",
                 items_sent, sb.live_items, column_writes, sb.draws_seen, sb.clears_seen);
        $display("Coverage: %0d restarts, frame filled %0d times, %0d mismatches.",
                 sb.restarts, sb.frame_fills, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin : run_limit
        #RUN_LIMIT_NS;
        $display("Regression FAIL");
        $finish;
    end

endmodule
